// ===== hw/rtl/tsra_pkg.sv =====
// shared types and constants for the texture slot refcount allocator
package tsra_pkg;

  localparam int SLOTS      = 64;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SLOT_CNT_W = $clog2(SLOTS + 1);

  localparam int KEY_W      = 32;
  localparam int BANK_W     = 6;
  localparam int SBANK_W    = 7;
  localparam int REFS_W     = 16;
  localparam int ADDR_W     = 32;
  localparam int POOL_W     = 28;
  localparam int IMG_W      = 24;
  localparam int SIZE_W     = 25;
  localparam int NSLOTS_W   = 7;
  localparam int SLOT_OUT_W = 6;
  localparam int STATUS_W   = 3;

  localparam logic [SIZE_W-1:0]  RT_SIZE       = 25'd1048832;
  localparam logic [SIZE_W-1:0]  HDR_EXTRA     = 25'd128;
  localparam logic [SBANK_W-1:0] BANK_ANY_CODE = 7'd127;
  localparam logic [KEY_W-1:0]   KEY_NONE      = 32'hFFFF_FFFF;

  localparam logic [ADDR_W-1:0]   POOL_BASE_RST = 32'd0;
  localparam logic [POOL_W-1:0]   POOL_SIZE_RST = 28'd10485760;
  localparam logic [NSLOTS_W-1:0] NSLOTS_RST    = 7'd64;

  // register indexes (word addresses on the configuration port)
  localparam logic [1:0] REG_POOL_BASE = 2'd0;
  localparam logic [1:0] REG_POOL_SIZE = 2'd1;
  localparam logic [1:0] REG_NSLOTS    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NEW      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SLOT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_POOL_FUL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_CLEAR
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SBANK_W-1:0] bank;
    logic [REFS_W-1:0]  refs;
    logic [ADDR_W-1:0]  addr;
  } entry_t;

  localparam entry_t ENTRY_RST = '{key: KEY_NONE, bank: BANK_ANY_CODE,
                                   refs: '0, addr: '0};

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic              clear;
  } tbl_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   pool_base;
    logic [POOL_W-1:0]   pool_size;
    logic [NSLOTS_W-1:0] slots_in_use;
  } cfg_t;

  typedef struct packed {
    logic                  mode;
    logic [KEY_W-1:0]      tex_key;
    logic [BANK_W-1:0]     bank;
    logic                  bank_any;
    logic                  render_target;
    logic [IMG_W-1:0]      image_total_size;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_OUT_W-1:0] slot;
    logic [ADDR_W-1:0]     address;
    logic [REFS_W-1:0]     ref_count;
  } res_t;

endpackage

// ===== hw/rtl/tsra_table.sv =====
// slot table memory with per-entry valid bits
module tsra_table (
  input  logic             clk,
  input  logic             rst,
  input  tsra_pkg::tbl_req_t req,
  input  tsra_pkg::entry_t   wr_data,
  output tsra_pkg::entry_t   rd_data
);

  tsra_pkg::entry_t mem [tsra_pkg::SLOTS];
  logic [tsra_pkg::SLOTS-1:0] valid;
  tsra_pkg::entry_t mem_q;
  logic valid_q;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= wr_data;
    end
    if (req.rd_en) begin
      mem_q <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (req.rd_en) begin
      valid_q <= valid[req.rd_addr];
    end
  end

  // an entry never written since reset or clear reads as its reset value
  assign rd_data = valid_q ? mem_q : tsra_pkg::ENTRY_RST;

endmodule

// ===== hw/rtl/tsra_ctrl.sv =====
// scan sequencer, hit/free decision and bump allocator
module tsra_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  tsra_pkg::cfg_t     cfg,
  input  logic               req_valid,
  input  tsra_pkg::req_t     req_in,
  output logic               req_ready,
  input  logic               out_free,
  output logic               res_load,
  output tsra_pkg::res_t     res,
  output tsra_pkg::tbl_req_t tbl_req,
  output tsra_pkg::entry_t   tbl_wr_data,
  input  tsra_pkg::entry_t   tbl_rd_data
);

  tsra_pkg::state_t state, state_next;

  tsra_pkg::req_t                     req, req_next;
  logic [tsra_pkg::SLOT_CNT_W-1:0]    n_eff, n_eff_next;
  logic [tsra_pkg::SLOT_CNT_W-1:0]    cnt, cnt_next;
  logic                               rd_pend, rd_pend_next;
  logic [tsra_pkg::SLOT_W-1:0]        rd_idx, rd_idx_next;
  logic                               hit, hit_next;
  logic [tsra_pkg::SLOT_W-1:0]        hit_idx, hit_idx_next;
  tsra_pkg::entry_t                   hit_ent, hit_ent_next;
  logic                               free_found, free_found_next;
  logic [tsra_pkg::SLOT_W-1:0]        free_idx, free_idx_next;
  logic [tsra_pkg::POOL_W-1:0]        pool_used, pool_used_next;

  logic                               accept;
  logic                               issue;
  logic                               match;
  logic [tsra_pkg::SIZE_W-1:0]        size;
  logic [tsra_pkg::POOL_W:0]          sum;
  logic                               fits;
  logic [tsra_pkg::REFS_W-1:0]        refs_inc;
  logic [31:0]                        nslots_wide;

  assign accept = req_valid && req_ready;
  assign issue  = (cnt < n_eff);
  assign nslots_wide = {{(32 - tsra_pkg::NSLOTS_W){1'b0}}, cfg.slots_in_use};

  assign match = (req.tex_key != tsra_pkg::KEY_NONE)
              && (tbl_rd_data.key == req.tex_key)
              && (req.bank_any || (tbl_rd_data.bank == {1'b0, req.bank}));

  assign size = req.render_target ? tsra_pkg::RT_SIZE
              : ({1'b0, req.image_total_size} + tsra_pkg::HDR_EXTRA);
  assign sum  = {1'b0, pool_used} + {{(tsra_pkg::POOL_W + 1 - tsra_pkg::SIZE_W){1'b0}}, size};
  assign fits = (sum < {1'b0, cfg.pool_size});
  assign refs_inc = hit_ent.refs + 16'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tsra_pkg::S_IDLE;
      cnt        <= '0;
      rd_pend    <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      pool_used  <= '0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      rd_pend    <= rd_pend_next;
      hit        <= hit_next;
      free_found <= free_found_next;
      pool_used  <= pool_used_next;
    end
  end

  always_ff @(posedge clk) begin
    req      <= req_next;
    n_eff    <= n_eff_next;
    rd_idx   <= rd_idx_next;
    hit_idx  <= hit_idx_next;
    hit_ent  <= hit_ent_next;
    free_idx <= free_idx_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tsra_pkg::S_IDLE: begin
        if (req_valid) begin
          state_next = req_in.mode ? tsra_pkg::S_CLEAR : tsra_pkg::S_SCAN;
        end
      end
      tsra_pkg::S_SCAN: begin
        if (!issue && !rd_pend) begin
          state_next = tsra_pkg::S_DECIDE;
        end
      end
      tsra_pkg::S_DECIDE, tsra_pkg::S_CLEAR: begin
        if (out_free) begin
          state_next = tsra_pkg::S_IDLE;
        end
      end
      default: state_next = tsra_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    req_ready       = (state == tsra_pkg::S_IDLE);
    req_next        = req;
    n_eff_next      = n_eff;
    cnt_next        = cnt;
    rd_pend_next    = 1'b0;
    rd_idx_next     = rd_idx;
    hit_next        = hit;
    hit_idx_next    = hit_idx;
    hit_ent_next    = hit_ent;
    free_found_next = free_found;
    free_idx_next   = free_idx;
    pool_used_next  = pool_used;
    res_load        = 1'b0;
    res             = '0;
    tbl_req         = '0;
    tbl_wr_data     = hit_ent;

    case (state)
      tsra_pkg::S_IDLE: begin
        if (accept) begin
          req_next        = req_in;
          n_eff_next      = (nslots_wide > 32'(tsra_pkg::SLOTS))
                          ? tsra_pkg::SLOT_CNT_W'(tsra_pkg::SLOTS)
                          : tsra_pkg::SLOT_CNT_W'(cfg.slots_in_use);
          cnt_next        = '0;
          hit_next        = 1'b0;
          free_found_next = 1'b0;
        end
      end
      tsra_pkg::S_SCAN: begin
        tbl_req.rd_en   = issue;
        tbl_req.rd_addr = tsra_pkg::SLOT_W'(cnt);
        if (issue) begin
          cnt_next     = cnt + tsra_pkg::SLOT_CNT_W'(1);
          rd_pend_next = 1'b1;
          rd_idx_next  = tsra_pkg::SLOT_W'(cnt);
        end
        if (rd_pend) begin
          // keep the lowest hit and the lowest free slot
          if (match && !hit) begin
            hit_next     = 1'b1;
            hit_idx_next = rd_idx;
            hit_ent_next = tbl_rd_data;
          end
          if ((tbl_rd_data.refs == '0) && !free_found) begin
            free_found_next = 1'b1;
            free_idx_next   = rd_idx;
          end
        end
      end
      tsra_pkg::S_DECIDE: begin
        if (out_free) begin
          res_load = 1'b1;
          if (hit) begin
            tbl_req.wr_en    = 1'b1;
            tbl_req.wr_addr  = hit_idx;
            tbl_wr_data      = hit_ent;
            tbl_wr_data.refs = refs_inc;
            res.status       = tsra_pkg::ST_HIT;
            res.slot         = tsra_pkg::SLOT_OUT_W'(hit_idx);
            res.address      = hit_ent.addr;
            res.ref_count    = refs_inc;
          end else if (!free_found) begin
            res.status = tsra_pkg::ST_NO_SLOT;
          end else if (!fits) begin
            res.status = tsra_pkg::ST_POOL_FUL;
            res.slot   = tsra_pkg::SLOT_OUT_W'(free_idx);
          end else begin
            tbl_req.wr_en    = 1'b1;
            tbl_req.wr_addr  = free_idx;
            tbl_wr_data.key  = req.tex_key;
            tbl_wr_data.bank = req.bank_any ? tsra_pkg::BANK_ANY_CODE : {1'b0, req.bank};
            tbl_wr_data.refs = 16'd1;
            tbl_wr_data.addr = cfg.pool_base
                             + {{(tsra_pkg::ADDR_W - tsra_pkg::POOL_W){1'b0}}, pool_used};
            pool_used_next   = sum[tsra_pkg::POOL_W-1:0];
            res.status       = tsra_pkg::ST_NEW;
            res.slot         = tsra_pkg::SLOT_OUT_W'(free_idx);
            res.address      = tbl_wr_data.addr;
            res.ref_count    = 16'd1;
          end
        end
      end
      tsra_pkg::S_CLEAR: begin
        if (out_free) begin
          res_load       = 1'b1;
          res.status     = tsra_pkg::ST_CLEARED;
          tbl_req.clear  = 1'b1;
          pool_used_next = '0;
        end
      end
      default: ;
    endcase
  end

  a_write_with_result: assert property (@(posedge clk) disable iff (rst)
    tbl_req.wr_en |-> (res_load && (state == tsra_pkg::S_DECIDE)))
    else $error("table written without a result");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == tsra_pkg::S_SCAN) |-> (cnt <= n_eff))
    else $error("scan counter passed the slot count");

  a_clear_pool: assert property (@(posedge clk) disable iff (rst)
    tbl_req.clear |=> (pool_used == '0))
    else $error("pool not emptied by clear");

  a_hit_writes: assert property (@(posedge clk) disable iff (rst)
    (res_load && (state == tsra_pkg::S_DECIDE) && hit) |-> tbl_req.wr_en)
    else $error("hit without count update");

endmodule

// ===== hw/rtl/texture_slot_refcount_allocator_top.sv =====
// top level: register port, stream ports, output register, table and sequencer
// a load request scans table slots 0 to n - 1, where n is min(slots_in_use, 64);
//   the table memory is read one slot a cycle
// a new request is taken only once the previous one has loaded its result
// the result sits in an output register, so a new request is taken while it waits
// reset: registers go to their reset values and the slot valid bits are cleared at once
module texture_slot_refcount_allocator_top (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // requests
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // tex_key, bank, bank_any, render_target, image_total_size
  input  logic        s_tuser,  // mode
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,  // slot, address, ref_count, zero pad
  output logic [2:0]  m_tuser   // status
);

  tsra_pkg::cfg_t     cfg;
  tsra_pkg::req_t     req_in;
  tsra_pkg::res_t     res, res_q;
  tsra_pkg::tbl_req_t tbl_req;
  tsra_pkg::entry_t   tbl_wr_data, tbl_rd_data;
  logic               res_load;
  logic               out_free;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pool_base    <= tsra_pkg::POOL_BASE_RST;
      cfg.pool_size    <= tsra_pkg::POOL_SIZE_RST;
      cfg.slots_in_use <= tsra_pkg::NSLOTS_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        tsra_pkg::REG_POOL_BASE: cfg.pool_base    <= pwdata;
        tsra_pkg::REG_POOL_SIZE: cfg.pool_size    <= pwdata[tsra_pkg::POOL_W-1:0];
        tsra_pkg::REG_NSLOTS:    cfg.slots_in_use <= pwdata[tsra_pkg::NSLOTS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      tsra_pkg::REG_POOL_BASE: prdata = cfg.pool_base;
      tsra_pkg::REG_POOL_SIZE: prdata = {{(32 - tsra_pkg::POOL_W){1'b0}}, cfg.pool_size};
      tsra_pkg::REG_NSLOTS:    prdata = {{(32 - tsra_pkg::NSLOTS_W){1'b0}}, cfg.slots_in_use};
      default:                 prdata = '0;
    endcase
  end

  assign req_in.mode             = s_tuser;
  assign req_in.tex_key          = s_tdata[31:0];
  assign req_in.bank             = s_tdata[37:32];
  assign req_in.bank_any         = s_tdata[38];
  assign req_in.render_target    = s_tdata[39];
  assign req_in.image_total_size = s_tdata[63:40];

  assign out_free = !m_tvalid || m_tready;

  // output register: holds one finished transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_q <= res;
    end
  end

  assign m_tuser = res_q.status;
  assign m_tdata = {2'b00, res_q.ref_count, res_q.address, res_q.slot};

  tsra_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .req_valid   (s_tvalid),
    .req_in      (req_in),
    .req_ready   (s_tready),
    .out_free    (out_free),
    .res_load    (res_load),
    .res         (res),
    .tbl_req     (tbl_req),
    .tbl_wr_data (tbl_wr_data),
    .tbl_rd_data (tbl_rd_data)
  );

  tsra_table u_table (
    .clk     (clk),
    .rst     (rst),
    .req     (tbl_req),
    .wr_data (tbl_wr_data),
    .rd_data (tbl_rd_data)
  );

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for the texture slot refcount allocator
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 3_000_000;

  logic        clk;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;  // tex_key, bank, bank_any, render_target, image_total_size
  logic        s_tuser = 1'b0; // mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;        // slot, address, ref_count, zero pad
  logic [2:0]  m_tuser;        // status

  texture_slot_refcount_allocator_top uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // shadow copy of the slot table, pool and registers
  logic [tsra_pkg::KEY_W-1:0]    tbl_key  [tsra_pkg::SLOTS];
  logic [tsra_pkg::SBANK_W-1:0]  tbl_bank [tsra_pkg::SLOTS];
  logic [tsra_pkg::REFS_W-1:0]   tbl_refs [tsra_pkg::SLOTS];
  logic [tsra_pkg::ADDR_W-1:0]   tbl_addr [tsra_pkg::SLOTS];
  logic [tsra_pkg::POOL_W-1:0]   pool_used;
  logic [tsra_pkg::ADDR_W-1:0]   cfg_base;
  logic [tsra_pkg::POOL_W-1:0]   cfg_size;
  logic [tsra_pkg::NSLOTS_W-1:0] cfg_nslots;

  tsra_pkg::res_t pending_results[$];
  int             mis_main = 0;
  int             mis_res = 0;
  int             cycle_count = 0;
  bit             tx_idle = 1'b0;
  bit             rx_idle = 1'b0;
  int             rx_stall = 0;
  logic [31:0]    keys [6];
  logic [23:0]    img_cap = 24'd1000;

  typedef struct {
    tsra_pkg::req_t r;
    bit             typed;
    tsra_pkg::res_t want;
  } dir_row_t;

  function automatic void table_clear();
    for (int i = 0; i < tsra_pkg::SLOTS; i++) begin
      tbl_key[i]  = tsra_pkg::KEY_NONE;
      tbl_bank[i] = tsra_pkg::BANK_ANY_CODE;
      tbl_refs[i] = '0;
      tbl_addr[i] = '0;
    end
    pool_used = '0;
  endfunction

  function automatic tsra_pkg::res_t predict_lookup(tsra_pkg::req_t r);
    tsra_pkg::res_t o;
    int             n;
    int             hit;
    int             fr;
    logic [63:0]    need;
    o = '0;
    n = (int'(cfg_nslots) > tsra_pkg::SLOTS) ? tsra_pkg::SLOTS : int'(cfg_nslots);
    if (r.mode) begin
      table_clear();
      o.status = tsra_pkg::ST_CLEARED;
      return o;
    end
    hit = -1;
    if (r.tex_key != tsra_pkg::KEY_NONE) begin
      for (int i = 0; i < n; i++)
        if (hit < 0 && tbl_key[i] == r.tex_key &&
            (r.bank_any || tbl_bank[i] == {1'b0, r.bank}))
          hit = i;
    end
    if (hit >= 0) begin
      tbl_refs[hit] = tbl_refs[hit] + 16'd1;
      o.status    = tsra_pkg::ST_HIT;
      o.slot      = hit[tsra_pkg::SLOT_OUT_W-1:0];
      o.address   = tbl_addr[hit];
      o.ref_count = tbl_refs[hit];
      return o;
    end
    fr = -1;
    for (int i = 0; i < n; i++)
      if (fr < 0 && tbl_refs[i] == '0)
        fr = i;
    if (fr < 0) begin
      o.status = tsra_pkg::ST_NO_SLOT;
      return o;
    end
    need = r.render_target ? 64'(tsra_pkg::RT_SIZE)
         : 64'(r.image_total_size) + 64'(tsra_pkg::HDR_EXTRA);
    if (64'(pool_used) + need >= 64'(cfg_size)) begin
      o.status = tsra_pkg::ST_POOL_FUL;
      o.slot   = fr[tsra_pkg::SLOT_OUT_W-1:0];
      return o;
    end
    tbl_key[fr]  = r.tex_key;
    tbl_bank[fr] = r.bank_any ? tsra_pkg::BANK_ANY_CODE : {1'b0, r.bank};
    tbl_refs[fr] = 16'd1;
    tbl_addr[fr] = cfg_base + 32'(pool_used);
    pool_used    = tsra_pkg::POOL_W'(64'(pool_used) + need);
    o.status    = tsra_pkg::ST_NEW;
    o.slot      = fr[tsra_pkg::SLOT_OUT_W-1:0];
    o.address   = tbl_addr[fr];
    o.ref_count = 16'd1;
    return o;
  endfunction

  function automatic tsra_pkg::req_t mk_req(bit md, logic [31:0] k, logic [5:0] b, bit any,
                                            bit rt, logic [23:0] img);
    tsra_pkg::req_t r;
    r.mode             = md;
    r.tex_key          = k;
    r.bank             = b;
    r.bank_any         = any;
    r.render_target    = rt;
    r.image_total_size = img;
    return r;
  endfunction

  function automatic tsra_pkg::res_t mk_res(logic [2:0] st, logic [5:0] sl, logic [31:0] a,
                                            logic [15:0] rc);
    tsra_pkg::res_t o;
    o.status    = st;
    o.slot      = sl;
    o.address   = a;
    o.ref_count = rc;
    return o;
  endfunction

  function automatic tsra_pkg::req_t rand_req();
    tsra_pkg::req_t r;
    int             pick;
    r.mode = ($urandom_range(0, 39) == 0);
    pick = $urandom_range(0, 15);
    if (pick < 11)
      r.tex_key = keys[pick % 6];
    else if (pick < 13)
      r.tex_key = tsra_pkg::KEY_NONE;
    else
      r.tex_key = $urandom();
    r.bank = ($urandom_range(0, 3) == 0) ? 6'($urandom()) : 6'($urandom_range(0, 2));
    r.bank_any      = ($urandom_range(0, 3) == 0);
    r.render_target = ($urandom_range(0, 7) == 0);
    case ($urandom_range(0, 9))
      0:       r.image_total_size = 24'($urandom());
      1:       r.image_total_size = 24'hFF_FFFF;
      2:       r.image_total_size = '0;
      default: r.image_total_size = 24'($urandom_range(0, int'(img_cap)));
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(string what);
    if (mis_main + mis_res < 10)
      $display("mismatch: %s", what);
    mis_main++;
  endtask

  // one request transfer; the expectation is queued at the accepting edge
  task automatic send_req(tsra_pkg::req_t r, bit typed, tsra_pkg::res_t want);
    tsra_pkg::res_t p;
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.mode;
    s_tdata  <= {r.image_total_size, r.render_target, r.bank_any, r.bank, r.tex_key};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    p = predict_lookup(r);
    pending_results.push_back(typed ? want : p);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // write a register, then read it back
  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    logic [31:0] rd;
    logic [31:0] want;
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      tsra_pkg::REG_POOL_BASE: cfg_base   = val;
      tsra_pkg::REG_POOL_SIZE: cfg_size   = val[tsra_pkg::POOL_W-1:0];
      default:                 cfg_nslots = val[tsra_pkg::NSLOTS_W-1:0];
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      tsra_pkg::REG_POOL_BASE: want = cfg_base;
      tsra_pkg::REG_POOL_SIZE: want = 32'(cfg_size);
      default:                 want = 32'(cfg_nslots);
    endcase
    if (rd !== want)
      flag_mismatch($sformatf("register %0d read %h, want %h", idx, rd, want));
  endtask

  // result side: checking and random back-pressure
  always @(posedge clk) begin
    tsra_pkg::res_t got;
    tsra_pkg::res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = tsra_pkg::res_t'({m_tuser, m_tdata[5:0], m_tdata[37:6], m_tdata[53:38]});
      if (pending_results.size() == 0) begin
        if (mis_main + mis_res < 10)
          $display("mismatch: result with nothing expected, status %0d slot %0d",
                   got.status, got.slot);
        mis_res++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          if (mis_main + mis_res < 10)
            $display("mismatch: want st %0d slot %0d addr %h refs %0d, got st %0d slot %0d addr %h refs %0d",
                     want.status, want.slot, want.address, want.ref_count,
                     got.status, got.slot, got.address, got.ref_count);
          mis_res++;
        end
      end
    end
    if (rx_stall > 0) begin
      rx_stall--;
      m_tready <= 1'b0;
    end else if (rx_idle && $urandom_range(0, 5) == 0) begin
      rx_stall = $urandom_range(1, 7) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    dir_row_t       rows[$];
    tsra_pkg::req_t kreq;
    int             count;
    bit             do_clear;

    table_clear();
    cfg_base   = tsra_pkg::POOL_BASE_RST;
    cfg_size   = tsra_pkg::POOL_SIZE_RST;
    cfg_nslots = tsra_pkg::NSLOTS_RST;

    // reset values: base 0, pool 10485760, 64 slots
    rows.push_back('{r: mk_req(1'b0, 32'd0, 6'd0, 1'b0, 1'b0, 24'd0), typed: 1'b1,
                     want: mk_res(tsra_pkg::ST_NEW, 6'd0, 32'd0, 16'd1)});
    rows.push_back('{r: mk_req(1'b0, 32'd0, 6'd0, 1'b0, 1'b0, 24'd0), typed: 1'b1,
                     want: mk_res(tsra_pkg::ST_HIT, 6'd0, 32'd0, 16'd2)});
    // same key, other bank: miss
    rows.push_back('{r: mk_req(1'b0, 32'd0, 6'd5, 1'b0, 1'b0, 24'd0), typed: 1'b1,
                     want: mk_res(tsra_pkg::ST_NEW, 6'd1, 32'd128, 16'd1)});
    // wildcard takes the lowest matching slot
    rows.push_back('{r: mk_req(1'b0, 32'd0, 6'd9, 1'b1, 1'b0, 24'd0), typed: 1'b1,
                     want: mk_res(tsra_pkg::ST_HIT, 6'd0, 32'd0, 16'd3)});
    // render target ignores the image size
    rows.push_back('{r: mk_req(1'b0, 32'd1, 6'd0, 1'b1, 1'b1, 24'hFF_FFFF), typed: 1'b1,
                     want: mk_res(tsra_pkg::ST_NEW, 6'd2, 32'd256, 16'd1)});
    // a specific bank never matches a wildcard-stored slot; largest image overflows
    rows.push_back('{r: mk_req(1'b0, 32'd1, 6'd3, 1'b0, 1'b0, 24'hFF_FFFF), typed: 1'b1,
                     want: mk_res(tsra_pkg::ST_POOL_FUL, 6'd3, 32'd0, 16'd0)});
    rows.push_back('{r: mk_req(1'b0, 32'd1, 6'd63, 1'b1, 1'b0, 24'd0), typed: 1'b0,
                     want: '0});
    // the no-key value never hits
    rows.push_back('{r: mk_req(1'b0, tsra_pkg::KEY_NONE, 6'd0, 1'b0, 1'b0, 24'd0),
                     typed: 1'b0, want: '0});
    rows.push_back('{r: mk_req(1'b0, tsra_pkg::KEY_NONE, 6'd0, 1'b0, 1'b0, 24'd0),
                     typed: 1'b0, want: '0});
    rows.push_back('{r: mk_req(1'b0, tsra_pkg::KEY_NONE, 6'd0, 1'b1, 1'b0, 24'd1),
                     typed: 1'b0, want: '0});
    rows.push_back('{r: mk_req(1'b1, tsra_pkg::KEY_NONE, 6'd63, 1'b1, 1'b1, 24'hFF_FFFF),
                     typed: 1'b1,
                     want: mk_res(tsra_pkg::ST_CLEARED, 6'd0, 32'd0, 16'd0)});
    rows.push_back('{r: mk_req(1'b0, 32'd0, 6'd0, 1'b0, 1'b0, 24'd0), typed: 1'b1,
                     want: mk_res(tsra_pkg::ST_NEW, 6'd0, 32'd0, 16'd1)});
    rows.push_back('{r: mk_req(1'b0, 32'hFFFF_FFFE, 6'd63, 1'b0, 1'b1, 24'd0), typed: 1'b0,
                     want: '0});
    rows.push_back('{r: mk_req(1'b0, 32'hFFFF_FFFE, 6'd63, 1'b0, 1'b0, 24'd0), typed: 1'b0,
                     want: '0});
    rows.push_back('{r: mk_req(1'b0, 32'hAAAA_AAAA, 6'd42, 1'b0, 1'b0, 24'h55_5555),
                     typed: 1'b0, want: '0});
    rows.push_back('{r: mk_req(1'b0, 32'h5555_5555, 6'd21, 1'b1, 1'b1, 24'hAA_AAAA),
                     typed: 1'b0, want: '0});
    rows.push_back('{r: mk_req(1'b0, 32'hAAAA_AAAA, 6'd42, 1'b0, 1'b0, 24'd0), typed: 1'b0,
                     want: '0});
    rows.push_back('{r: mk_req(1'b1, 32'd0, 6'd0, 1'b0, 1'b0, 24'd0), typed: 1'b1,
                     want: mk_res(tsra_pkg::ST_CLEARED, 6'd0, 32'd0, 16'd0)});

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    tx_idle = 1'b1;
    rx_idle = 1'b1;
    foreach (rows[i])
      send_req(rows[i].r, rows[i].typed, rows[i].want);

    // single slot at full speed: hits pile up, then a new key finds no free slot
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    reg_write(tsra_pkg::REG_NSLOTS, 32'd1);
    reg_write(tsra_pkg::REG_POOL_SIZE, 32'd300);
    kreq = mk_req(1'b0, 32'h1234_5678, 6'd7, 1'b0, 1'b0, 24'd100);
    send_req(kreq, 1'b1, mk_res(tsra_pkg::ST_NEW, 6'd0, 32'd0, 16'd1));
    for (int i = 0; i < 8; i++)
      send_req(kreq, 1'b0, '0);
    send_req(mk_req(1'b0, 32'h0BAD_F00D, 6'd7, 1'b0, 1'b0, 24'd100), 1'b1,
             mk_res(tsra_pkg::ST_NO_SLOT, 6'd0, 32'd0, 16'd0));
    send_req(kreq, 1'b1, mk_res(tsra_pkg::ST_HIT, 6'd0, 32'd0, 16'd10));

    for (int ph = 0; ph < 8; ph++) begin
      do_clear = 1'b1;
      tx_idle  = 1'b1;
      rx_idle  = 1'b1;
      for (int i = 0; i < 6; i++)
        keys[i] = $urandom();
      case (ph)
        0: begin
          reg_write(tsra_pkg::REG_POOL_BASE, 32'd0);
          reg_write(tsra_pkg::REG_POOL_SIZE, 32'(tsra_pkg::POOL_SIZE_RST));
          reg_write(tsra_pkg::REG_NSLOTS, 32'd64);
          img_cap = 24'd200000;
          count = 180;
        end
        1: begin
          reg_write(tsra_pkg::REG_POOL_BASE, 32'hFFFF_FF00);
          reg_write(tsra_pkg::REG_POOL_SIZE, 32'hFFFF_FFFF);
          reg_write(tsra_pkg::REG_NSLOTS, 32'd127);
          img_cap = 24'hFF_FFFF;
          count = 140;
        end
        2: begin
          reg_write(tsra_pkg::REG_POOL_BASE, $urandom());
          reg_write(tsra_pkg::REG_POOL_SIZE, 32'd0);
          reg_write(tsra_pkg::REG_NSLOTS, 32'd8);
          count = 60;
        end
        3: begin
          reg_write(tsra_pkg::REG_POOL_SIZE, $urandom());
          reg_write(tsra_pkg::REG_NSLOTS, 32'd0);
          tx_idle = 1'b0;
          rx_idle = 1'b0;
          count = 30;
        end
        4: begin
          reg_write(tsra_pkg::REG_POOL_BASE, $urandom());
          reg_write(tsra_pkg::REG_POOL_SIZE, $urandom_range(300, 5000));
          reg_write(tsra_pkg::REG_NSLOTS, 32'd1);
          img_cap = 24'd600;
          count = 120;
        end
        5: begin
          // shrink the pool below what is already handed out
          do_clear = 1'b0;
          reg_write(tsra_pkg::REG_POOL_SIZE, 32'(pool_used >> 1));
          reg_write(tsra_pkg::REG_NSLOTS, 32'd3);
          count = 100;
        end
        6: begin
          // upper pwdata bits must be dropped
          reg_write(tsra_pkg::REG_POOL_BASE, $urandom());
          reg_write(tsra_pkg::REG_POOL_SIZE, 32'hAFFF_FFFF);
          reg_write(tsra_pkg::REG_NSLOTS, 32'd64);
          img_cap = 24'd1000;
          count = 200;
        end
        default: begin
          reg_write(tsra_pkg::REG_POOL_BASE, $urandom());
          reg_write(tsra_pkg::REG_POOL_SIZE, $urandom());
          reg_write(tsra_pkg::REG_NSLOTS, $urandom_range(2, 63));
          img_cap = 24'd100000;
          tx_idle = 1'b0;
          rx_idle = 1'b0;
          count = 180;
        end
      endcase
      if (do_clear)
        send_req(mk_req(1'b1, $urandom(), 6'($urandom()), 1'($urandom()), 1'($urandom()),
                        24'($urandom())), 1'b0, '0);
      for (int i = 0; i < count; i++)
        send_req(rand_req(), 1'b0, '0);
    end

    wait_idle();
    repeat (80) @(posedge clk);
    if (pending_results.size() != 0)
      flag_mismatch("results still outstanding at the end");
    if (mis_main == 0 && mis_res == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== texture_slot_refcount_allocator_top.f =====
hw/rtl/tsra_pkg.sv
hw/rtl/tsra_table.sv
hw/rtl/tsra_ctrl.sv
hw/rtl/texture_slot_refcount_allocator_top.sv
dv/testbench.sv
